// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Byte-level commands
  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_NACK = 3'd4
  } cmd_t;

  // Item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  // Configuration register map
  localparam int unsigned  PADDR_W             = 2;
  localparam logic [1:0]   ADDR_PHASE_TICKS    = 2'd0;
  localparam logic [15:0]  PHASE_TICKS_RESET   = 16'd60;

  // Bits per byte transfer
  localparam logic [3:0]   BYTE_BITS = 4'd8;

  // Phase index of a command sequence
  typedef logic [2:0] phase_t;

  // Output queue geometry
  localparam int unsigned QUEUE_DEPTH = 3;
  localparam int unsigned QUEUE_IDX_W = 2;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

  // One result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
    logic       rejected;
  } res_t;

endpackage

// ===== hw/rtl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus state and one-item step: applies one tick or command per cycle.
// ----------------------------------------------------------------------------
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_kind,
  input  logic [2:0]  item_command,
  input  logic [7:0]  item_write_data,
  input  logic        item_sda_in,
  input  logic [15:0] phase_ticks,
  output res_t        result
);

  logic        scl, sda, busy, ack_flag;
  phase_t      phase;
  logic [3:0]  bit_count;
  logic [15:0] tick_count;
  logic [7:0]  shift_reg, last_read;
  cmd_t        cur_cmd;

  logic        scl_next, sda_next, busy_next, ack_flag_next;
  phase_t      phase_next;
  logic [3:0]  bit_count_next;
  logic [15:0] tick_count_next;
  logic [7:0]  shift_reg_next, last_read_next;
  cmd_t        cur_cmd_next;
  logic        done, rejected;

  // Pin action taken on entering phase p of a command
  function automatic pins_t enter_pins(cmd_t cmd, phase_t p, pins_t cur, logic msb);
    pins_t r;
    r = cur;
    case (cmd)
      CMD_START: begin
        if (p == 3'd0)      r.sda = 1'b1;
        else if (p == 3'd1) r.scl = 1'b1;
        else if (p == 3'd2) r.sda = 1'b0;
        else                r.scl = 1'b0;
      end
      CMD_STOP: begin
        if (p == 3'd0)      r.scl = 1'b0;
        else if (p == 3'd1) r.sda = 1'b0;
        else if (p == 3'd2) r.scl = 1'b1;
        else                r.sda = 1'b1;
      end
      CMD_WRITE: begin
        if (p == 3'd0 || p == 3'd3) r.scl = 1'b0;
        else if (p == 3'd1)         r.sda = msb;
        else if (p == 3'd4)         r.sda = 1'b1;
        else                        r.scl = 1'b1;
      end
      default: begin
        if (p == 3'd0 || p == 3'd2 || p == 3'd5) r.scl = 1'b0;
        else if (p == 3'd1 || p == 3'd4)         r.scl = 1'b1;
        else                                     r.sda = (cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    logic [16:0] tick_inc;
    logic [15:0] limit;
    logic        enter_req;
    phase_t      enter_p;
    pins_t       pins;

    scl_next        = scl;
    sda_next        = sda;
    busy_next       = busy;
    phase_next      = phase;
    bit_count_next  = bit_count;
    tick_count_next = tick_count;
    shift_reg_next  = shift_reg;
    cur_cmd_next    = cur_cmd;
    ack_flag_next   = ack_flag;
    last_read_next  = last_read;
    done            = 1'b0;
    rejected        = 1'b0;
    enter_req       = 1'b0;
    enter_p         = '0;
    tick_inc        = {1'b0, tick_count} + 17'd1;
    limit           = (phase_ticks == '0) ? 16'd1 : phase_ticks;

    if (item_valid) begin
      if (item_kind == KIND_COMMAND) begin
        if (busy) begin
          rejected = 1'b1;
        end else if (item_command <= CMD_READ_NACK) begin
          busy_next      = 1'b1;
          cur_cmd_next   = cmd_t'(item_command);
          bit_count_next = '0;
          if (item_command == CMD_WRITE) shift_reg_next = item_write_data;
          if (item_command == CMD_READ_ACK || item_command == CMD_READ_NACK) begin
            shift_reg_next = '0;
            sda_next       = 1'b1;
          end
          enter_req = 1'b1;
        end
      end else if (busy) begin
        if (tick_inc >= {1'b0, limit}) begin
          tick_count_next = '0;
          case (cur_cmd)
            CMD_START, CMD_STOP: begin
              if (phase >= 3'd3) done = 1'b1;
              else begin
                enter_req = 1'b1;
                enter_p   = phase + 3'd1;
              end
            end
            CMD_WRITE: begin
              if (phase == 3'd2) begin
                shift_reg_next = {shift_reg[6:0], 1'b0};
                bit_count_next = bit_count + 4'd1;
                enter_req      = 1'b1;
                enter_p        = (bit_count_next < BYTE_BITS) ? 3'd0 : 3'd3;
              end else if (phase >= 3'd5) begin
                ack_flag_next = item_sda_in;
                scl_next      = 1'b0;
                done          = 1'b1;
              end else begin
                enter_req = 1'b1;
                enter_p   = phase + 3'd1;
              end
            end
            default: begin
              if (phase == 3'd1) begin
                shift_reg_next = {shift_reg[6:0], item_sda_in};
                bit_count_next = bit_count + 4'd1;
                enter_req      = 1'b1;
                enter_p        = (bit_count_next < BYTE_BITS) ? 3'd0 : 3'd2;
              end else if (phase >= 3'd5) begin
                last_read_next = shift_reg;
                done           = 1'b1;
              end else begin
                enter_req = 1'b1;
                enter_p   = phase + 3'd1;
              end
            end
          endcase
          if (done) begin
            busy_next  = 1'b0;
            phase_next = '0;
          end
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end
    end

    pins = enter_pins(cur_cmd_next, enter_p, '{scl: scl_next, sda: sda_next},
                      shift_reg_next[7]);
    if (enter_req) begin
      phase_next      = enter_p;
      tick_count_next = '0;
      scl_next        = pins.scl;
      sda_next        = pins.sda;
    end

    result.scl_out   = scl_next;
    result.sda_out   = sda_next;
    result.busy_res  = busy_next;
    result.done_res  = done;
    result.read_data = last_read_next;
    result.no_ack    = ack_flag_next;
    result.rejected  = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl        <= 1'b1;
      sda        <= 1'b1;
      busy       <= 1'b0;
      phase      <= '0;
      bit_count  <= '0;
      tick_count <= '0;
      shift_reg  <= '0;
      cur_cmd    <= CMD_START;
      ack_flag   <= 1'b0;
      last_read  <= '0;
    end else begin
      scl        <= scl_next;
      sda        <= sda_next;
      busy       <= busy_next;
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      tick_count <= tick_count_next;
      shift_reg  <= shift_reg_next;
      cur_cmd    <= cur_cmd_next;
      ack_flag   <= ack_flag_next;
      last_read  <= last_read_next;
    end
  end

endmodule

// ===== hw/rtl/i2cm_out_queue.sv =====
// ----------------------------------------------------------------------------
// i2cm_out_queue
// Small result queue between the engine and the output channel.
// ----------------------------------------------------------------------------
module i2cm_out_queue
  import i2cm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  res_t                   push_data,
  input  logic                   pop,
  output res_t                   head_data,
  output logic                   not_empty,
  output logic [QUEUE_CNT_W-1:0] count
);

  res_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] head, tail;

  function automatic logic [QUEUE_IDX_W-1:0] bump(logic [QUEUE_IDX_W-1:0] p);
    return (p == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_data = entries[head];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) entries[tail] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= bump(tail);
      if (pop)  head <= bump(head);
      count <= count + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end
  end

endmodule

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that runs one byte command at a time, paced by tick items.
// ----------------------------------------------------------------------------
// Each input item is either one tick of time or a byte command (start, stop,
// write byte and sample ACK, read byte with ACK, read byte with NACK), and
// each item gives exactly one result item: the SCL/SDA drive levels, busy,
// done, the last read byte, the no-ack flag and a rejected flag for a
// command that arrived while busy. Each SCL/SDA phase lasts phase_ticks
// ticks (zero acts as one); phase_ticks sits at byte address 0 of the APB
// port and should be written only while no command is in progress. The
// block takes one item per clock while in_stall is low: an accepted item is
// held in an input register, the engine applies it to the bus state in the
// next cycle, and its result lands in a three-entry output queue, so a result
// item is offered on the output once the input register and then the queue
// have registered it, and can be taken at the following edge. in_stall rises
// only when the queue and input register together hold three items, i.e. when
// the output side has stalled long enough to fill them.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [2:0]         command,
  input  logic [7:0]         write_data,
  input  logic               sda_in,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               scl_out,
  output logic               sda_out,
  output logic               busy_res,
  output logic               done_res,
  output logic [7:0]         read_data,
  output logic               no_ack,
  output logic               rejected
);

  logic [15:0] phase_ticks;

  // input register
  logic        in_reg_valid;
  logic        in_reg_kind;
  logic [2:0]  in_reg_command;
  logic [7:0]  in_reg_write_data;
  logic        in_reg_sda_in;

  logic                   in_accept, out_pop;
  logic [QUEUE_CNT_W-1:0] q_count;
  logic [QUEUE_CNT_W:0]   occupancy;
  res_t                   step_res, head_res;

  // APB: always ready, write on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_PHASE_TICKS) ? {16'd0, phase_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_PHASE_TICKS) begin
      phase_ticks <= pwdata[15:0];
    end
  end

  // Hold off input once the input register and queue could fill up.
  assign occupancy = {1'b0, q_count} + (QUEUE_CNT_W + 1)'(in_reg_valid);
  assign in_stall  = (occupancy >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) in_reg_valid <= 1'b0;
    else     in_reg_valid <= in_accept;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_kind       <= kind;
      in_reg_command    <= command;
      in_reg_write_data <= write_data;
      in_reg_sda_in     <= sda_in;
    end
  end

  i2cm_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (in_reg_valid),
    .item_kind       (in_reg_kind),
    .item_command    (in_reg_command),
    .item_write_data (in_reg_write_data),
    .item_sda_in     (in_reg_sda_in),
    .phase_ticks     (phase_ticks),
    .result          (step_res)
  );

  // Drop a result from the queue once the output side takes it.
  assign out_pop = out_valid && !out_stall;

  i2cm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_reg_valid),
    .push_data (step_res),
    .pop       (out_pop),
    .head_data (head_res),
    .not_empty (out_valid),
    .count     (q_count)
  );

  assign scl_out   = head_res.scl_out;
  assign sda_out   = head_res.sda_out;
  assign busy_res  = head_res.busy_res;
  assign done_res  = head_res.done_res;
  assign read_data = head_res.read_data;
  assign no_ack    = head_res.no_ack;
  assign rejected  = head_res.rejected;

  // The queue never overflows: a push into a full queue would lose an item.
  assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !out_pop |-> q_count < QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A command is rejected only while one is still running.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res)
    else $error("rejected item while not busy");

  // A finished command leaves the engine idle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // An accepted item reaches the engine in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_reg_valid)
    else $error("accepted item lost before engine");

endmodule
